// File: hdl/motor_channel_command_fsm_assert.svh
// Assertion macros for the motor channel command sequencer checker.
`ifndef MOTOR_CHANNEL_COMMAND_FSM_ASSERT_SVH
`define MOTOR_CHANNEL_COMMAND_FSM_ASSERT_SVH

// Same-cycle implication, sampled on clk, off while rst_n is low.
`define MCCF_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("mccf check failed");

// Next-cycle implication, sampled on clk, off while rst_n is low.
`define MCCF_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("mccf check failed");

`endif

// File: hdl/mccf_pkg.sv
// Shared types and constants of the motor channel command sequencer.
`default_nettype none

package mccf_pkg;

    localparam int CHANNELS_DEF    = 2;
    localparam int QUEUE_DEPTH_DEF = 2;

    localparam int KIND_W   = 4;
    localparam int WORD_W   = 32;
    localparam int STATUS_W = 3;
    localparam int REJ_W    = 16;

    // command kinds on the wire
    localparam logic [KIND_W-1:0] KIND_INIT1   = 4'd0;
    localparam logic [KIND_W-1:0] KIND_INIT2   = 4'd1;
    localparam logic [KIND_W-1:0] KIND_INIT3   = 4'd2;
    localparam logic [KIND_W-1:0] KIND_CTRL1   = 4'd3;
    localparam logic [KIND_W-1:0] KIND_CTRL2   = 4'd4;
    localparam logic [KIND_W-1:0] KIND_CTRL3   = 4'd5;
    localparam logic [KIND_W-1:0] KIND_CTRL4   = 4'd6;
    localparam logic [KIND_W-1:0] KIND_CALIB   = 4'd7;
    localparam logic [KIND_W-1:0] KIND_ENABLE  = 4'd8;
    localparam logic [KIND_W-1:0] KIND_DISABLE = 4'd9;
    localparam logic [KIND_W-1:0] KIND_TARGET  = 4'd10;
    localparam logic [KIND_W-1:0] KIND_TICK    = 4'd11;
    localparam logic [KIND_W-1:0] KIND_TIMEOUT = 4'd12;

    // setting word fields that steer behavior
    localparam int         CAL_EN_LSB  = 16;   // init1 low word, byte 2
    localparam int         TMO_EN_LSB  = 24;   // ctrl4 low word, byte 3
    localparam logic [7:0] TMO_EN_CODE = 8'd1;

    typedef enum logic [3:0] {
        OP_NONE,
        OP_INIT1,
        OP_INIT2,
        OP_INIT3,
        OP_CTRL1,
        OP_CTRL2,
        OP_CTRL3,
        OP_CTRL4,
        OP_CALIB,
        OP_ENABLE,
        OP_DISABLE,
        OP_TARGET,
        OP_TICK,
        OP_TIMEOUT
    } op_t;

    typedef enum logic [STATUS_W-1:0] {
        MODE_INIT    = 3'd0,
        MODE_CHANGE  = 3'd1,
        MODE_CALIB   = 3'd2,
        MODE_ENABLE  = 3'd3,
        MODE_DISABLE = 3'd4
    } mode_t;

    // classified command as it waits in the queue
    typedef struct packed {
        op_t  op;
        logic channel;
        logic chan_ok;
        logic arg;      // calib enable (init1), timeout enable (ctrl4), switch (tick)
    } cmd_t;

endpackage

`default_nettype wire

// File: hdl/mccf_if.sv
// Command and response channel interfaces of the motor channel command sequencer.
`default_nettype none

interface mccf_cmd_if;
    import mccf_pkg::*;

    logic              valid;
    logic              ready;
    logic [KIND_W-1:0] kind;
    logic              channel;
    logic [WORD_W-1:0] word_low;
    logic [WORD_W-1:0] word_high;
    logic              limit_switch;

    modport source (
        output valid, kind, channel, word_low, word_high, limit_switch,
        input  ready
    );
    modport sink (
        input  valid, kind, channel, word_low, word_high, limit_switch,
        output ready
    );
endinterface

interface mccf_rsp_if;
    import mccf_pkg::*;

    logic                valid;
    logic                ready;
    logic                accepted;
    logic                channel_out;
    logic [STATUS_W-1:0] status;
    logic                calib_done;
    logic                initialized;
    logic                calib_drive;
    logic [REJ_W-1:0]    reject_count;

    modport source (
        output valid, accepted, channel_out, status, calib_done, initialized,
               calib_drive, reject_count,
        input  ready
    );
    modport sink (
        input  valid, accepted, channel_out, status, calib_done, initialized,
               calib_drive, reject_count,
        output ready
    );
endinterface

`default_nettype wire

// File: hdl/mccf_front.sv
// Front end: takes command beats and classifies them into queue entries.
`default_nettype none

module mccf_front #(
    parameter int CHANNELS = mccf_pkg::CHANNELS_DEF
) (
    mccf_cmd_if.sink        cmd,
    input  logic            full,
    output logic            push,
    output mccf_pkg::cmd_t  push_cmd
);
    import mccf_pkg::*;

    op_t  op;
    logic arg;

    assign cmd.ready = !full;
    assign push      = cmd.valid && !full;

    always_comb
    begin
        op  = OP_NONE;
        arg = 1'b0;
        unique case (cmd.kind)
            KIND_INIT1:
            begin
                op  = OP_INIT1;
                arg = |cmd.word_low[CAL_EN_LSB +: 8];
            end
            KIND_INIT2:   op = OP_INIT2;
            KIND_INIT3:   op = OP_INIT3;
            KIND_CTRL1:   op = OP_CTRL1;
            KIND_CTRL2:   op = OP_CTRL2;
            KIND_CTRL3:   op = OP_CTRL3;
            KIND_CTRL4:
            begin
                op  = OP_CTRL4;
                arg = (cmd.word_low[TMO_EN_LSB +: 8] == TMO_EN_CODE);
            end
            KIND_CALIB:   op = OP_CALIB;
            KIND_ENABLE:  op = OP_ENABLE;
            KIND_DISABLE: op = OP_DISABLE;
            KIND_TARGET:  op = OP_TARGET;
            KIND_TICK:
            begin
                op  = OP_TICK;
                arg = cmd.limit_switch;
            end
            KIND_TIMEOUT: op = OP_TIMEOUT;
            default:      op = OP_NONE;   // unused kinds become OP_NONE and are refused
        endcase
    end

    always_comb
    begin
        push_cmd.op      = op;
        push_cmd.channel = cmd.channel;
        push_cmd.chan_ok = (int'(cmd.channel) < CHANNELS);
        push_cmd.arg     = arg;
    end

endmodule

`default_nettype wire

// File: hdl/mccf_queue.sv
// Short FIFO of classified commands between front end and back end.
`default_nettype none

module mccf_queue #(
    parameter int DEPTH = mccf_pkg::QUEUE_DEPTH_DEF
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            push,
    input  mccf_pkg::cmd_t  push_cmd,
    output logic            full,
    output logic            head_valid,
    output mccf_pkg::cmd_t  head,
    input  logic            pop
);
    import mccf_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    cmd_t             entries_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;

    assign full       = (count_reg == CNT_W'(DEPTH));
    assign head_valid = (count_reg != '0);
    assign head       = entries_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entries_reg[wr_ptr_reg] <= push_cmd;
        end
    end

endmodule

`default_nettype wire

// File: hdl/mccf_back.sv
// Back end: guarded read-modify-write of channel state and the response register.
`default_nettype none

module mccf_back #(
    parameter int CHANNELS = mccf_pkg::CHANNELS_DEF
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            head_valid,
    input  mccf_pkg::cmd_t  head,
    output logic            pop,
    mccf_rsp_if.source      rsp
);
    import mccf_pkg::*;

    localparam int CH_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

    typedef struct packed {
        logic                accepted;
        logic                channel_out;
        logic [STATUS_W-1:0] status;
        logic                calib_done;
        logic                initialized;
        logic                calib_drive;
        logic [REJ_W-1:0]    reject_count;
    } result_t;

    mode_t               mode_reg     [CHANNELS];
    mode_t               mode_next    [CHANNELS];
    logic [REJ_W-1:0]    rej_reg      [CHANNELS];
    logic [REJ_W-1:0]    rej_next     [CHANNELS];
    logic [CHANNELS-1:0] cal_reg,      cal_next;       // calibrated
    logic [CHANNELS-1:0] started_reg,  started_next;   // set-up under way
    logic [CHANNELS-1:0] finished_reg, finished_next;  // set-up complete
    logic [CHANNELS-1:0] rdy_reg,      rdy_next;       // channel initialized
    logic [CHANNELS-1:0] cal_en_reg,   cal_en_next;    // calibration enabled
    logic [CHANNELS-1:0] tmo_en_reg,   tmo_en_next;    // timeout monitor enabled
    logic                init_seen_reg, init_seen_next;

    logic                rsp_valid_reg;
    result_t             res_reg, res_next;

    logic [CH_W-1:0]     idx;
    logic                acc;
    logic                bump;
    mode_t               cur_mode;

    assign pop      = head_valid && (!rsp_valid_reg || rsp.ready);
    assign idx      = head.chan_ok ? CH_W'(head.channel) : '0;
    assign cur_mode = mode_reg[idx];

    always_comb
    begin
        mode_next      = mode_reg;
        rej_next       = rej_reg;
        cal_next       = cal_reg;
        started_next   = started_reg;
        finished_next  = finished_reg;
        rdy_next       = rdy_reg;
        cal_en_next    = cal_en_reg;
        tmo_en_next    = tmo_en_reg;
        init_seen_next = init_seen_reg;
        acc            = 1'b0;
        bump           = 1'b0;

        if (pop)
        begin
            if (head.op == OP_TIMEOUT)
            begin
                // timeout disables every enabled channel whose monitor is on
                for (int i = 0; i < CHANNELS; i++)
                begin
                    if (mode_reg[i] == MODE_ENABLE && tmo_en_reg[i])
                    begin
                        mode_next[i] = MODE_DISABLE;
                        acc          = 1'b1;
                    end
                end
            end
            else if (head.chan_ok)
            begin
                unique case (head.op)
                    OP_INIT1, OP_INIT2, OP_INIT3:
                    begin
                        if (!rdy_reg[idx])
                        begin
                            acc = 1'b1;
                            if (head.op == OP_INIT1)
                            begin
                                cal_en_next[idx] = head.arg;
                            end
                            if (head.op == OP_INIT3)
                            begin
                                init_seen_next = 1'b1;
                            end
                        end
                    end
                    OP_CTRL1:
                    begin
                        if (init_seen_reg)
                        begin
                            if (cur_mode == MODE_INIT || cur_mode == MODE_CHANGE ||
                                cur_mode == MODE_DISABLE)
                            begin
                                acc                = 1'b1;
                                mode_next[idx]     = MODE_CHANGE;
                                cal_next[idx]      = 1'b0;
                                started_next[idx]  = 1'b1;
                                finished_next[idx] = 1'b0;
                            end
                            else
                            begin
                                bump = 1'b1;
                            end
                        end
                    end
                    OP_CTRL2, OP_CTRL3, OP_CTRL4:
                    begin
                        if (init_seen_reg && started_reg[idx])
                        begin
                            acc = 1'b1;
                            if (head.op == OP_CTRL4)
                            begin
                                started_next[idx]  = 1'b0;
                                finished_next[idx] = 1'b1;
                                rdy_next[idx]      = 1'b1;
                                tmo_en_next[idx]   = head.arg;
                            end
                        end
                    end
                    OP_CALIB:
                    begin
                        if ((cur_mode == MODE_DISABLE || cur_mode == MODE_CHANGE) &&
                            finished_reg[idx])
                        begin
                            acc            = 1'b1;
                            mode_next[idx] = MODE_CALIB;
                            cal_next[idx]  = 1'b0;
                        end
                        else
                        begin
                            bump = 1'b1;
                        end
                    end
                    OP_ENABLE:
                    begin
                        if ((cur_mode == MODE_CALIB || cur_mode == MODE_DISABLE) &&
                            cal_reg[idx])
                        begin
                            acc            = 1'b1;
                            mode_next[idx] = MODE_ENABLE;
                        end
                        else
                        begin
                            bump = 1'b1;
                        end
                    end
                    OP_DISABLE:
                    begin
                        if (cur_mode == MODE_ENABLE)
                        begin
                            acc            = 1'b1;
                            mode_next[idx] = MODE_DISABLE;
                        end
                        else
                        begin
                            bump = 1'b1;
                        end
                    end
                    OP_TARGET:
                    begin
                        acc = 1'b1;
                    end
                    OP_TICK:
                    begin
                        if (cur_mode == MODE_CALIB)
                        begin
                            acc = 1'b1;
                            if (head.arg || !cal_en_reg[idx])
                            begin
                                cal_next[idx] = 1'b1;
                            end
                        end
                    end
                    default:
                    begin
                        acc = 1'b0;   // unused kind
                    end
                endcase

                // saturating reject count
                if (bump && rej_reg[idx] != '1)
                begin
                    rej_next[idx] = rej_reg[idx] + 1'b1;
                end
            end
        end
    end

    // report the addressed channel after the update
    always_comb
    begin
        res_next              = '0;
        res_next.accepted     = acc;
        res_next.channel_out  = head.channel;
        if (head.chan_ok)
        begin
            res_next.status       = mode_next[idx];
            res_next.calib_done   = cal_next[idx];
            res_next.initialized  = rdy_next[idx];
            res_next.calib_drive  = (mode_next[idx] == MODE_CALIB) && cal_en_next[idx] &&
                                    !cal_next[idx];
            res_next.reject_count = rej_next[idx];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < CHANNELS; i++)
            begin
                mode_reg[i] <= MODE_INIT;
                rej_reg[i]  <= '0;
            end
            cal_reg       <= '0;
            started_reg   <= '0;
            finished_reg  <= '0;
            rdy_reg       <= '0;
            cal_en_reg    <= '0;
            tmo_en_reg    <= '0;
            init_seen_reg <= 1'b0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            mode_reg      <= mode_next;
            rej_reg       <= rej_next;
            cal_reg       <= cal_next;
            started_reg   <= started_next;
            finished_reg  <= finished_next;
            rdy_reg       <= rdy_next;
            cal_en_reg    <= cal_en_next;
            tmo_en_reg    <= tmo_en_next;
            init_seen_reg <= init_seen_next;
            if (pop)
            begin
                rsp_valid_reg <= 1'b1;
            end
            else if (rsp.ready)
            begin
                rsp_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            res_reg <= res_next;
        end
    end

    assign rsp.valid        = rsp_valid_reg;
    assign rsp.accepted     = res_reg.accepted;
    assign rsp.channel_out  = res_reg.channel_out;
    assign rsp.status       = res_reg.status;
    assign rsp.calib_done   = res_reg.calib_done;
    assign rsp.initialized  = res_reg.initialized;
    assign rsp.calib_drive  = res_reg.calib_drive;
    assign rsp.reject_count = res_reg.reject_count;

endmodule

`default_nettype wire

// File: hdl/motor_channel_command_fsm.sv
// Top level of the motor channel command sequencer.
`default_nettype none

// Mode sequencer for CHANNELS motor channels. Each cmd beat is one decoded
// command (init words, four-part control set-up, calibrate, enable, disable,
// set target, calibration tick, timeout) for one channel; each produces
// exactly one rsp beat telling whether the command passed its guards and the
// addressed channel's mode, calibration-done, initialized, calibration drive
// and saturating reject count after it. Rejected commands are dropped; a
// rejected mode change bumps the reject count, save a ctrl1 refused before
// init3. A timeout disables every enabled channel whose timeout monitor is on.
// Throughput is one command per clock when rsp is not stalled and QUEUE_DEPTH
// is at least two. A cmd beat lands in the command queue at its accepting edge;
// the back end's combinational read-modify-write of channel state works off
// the queue head, its result caught in the response register when the head is
// popped, which waits while a response is stalled. The front end keeps taking
// commands while a response waits, until the QUEUE_DEPTH-entry queue fills.
// Only the setting bytes that steer behavior (calibration enable, timeout
// enable) are kept. No clearing pass after reset.
module motor_channel_command_fsm #(
    parameter int CHANNELS    = mccf_pkg::CHANNELS_DEF,     // 1..8
    parameter int QUEUE_DEPTH = mccf_pkg::QUEUE_DEPTH_DEF
) (
    input  wire          clk,
    input  wire          rst_n,
    mccf_cmd_if.sink     cmd,
    mccf_rsp_if.source   rsp
);
    import mccf_pkg::*;

    logic full;
    logic push;
    cmd_t push_cmd;
    logic head_valid;
    cmd_t head;
    logic pop;

    // classify command beats
    mccf_front #(
        .CHANNELS (CHANNELS)
    ) u_front (
        .cmd      (cmd),
        .full     (full),
        .push     (push),
        .push_cmd (push_cmd)
    );

    // decouples intake from execution
    mccf_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_cmd   (push_cmd),
        .full       (full),
        .head_valid (head_valid),
        .head       (head),
        .pop        (pop)
    );

    // guards, state update, response register
    mccf_back #(
        .CHANNELS (CHANNELS)
    ) u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .head_valid (head_valid),
        .head       (head),
        .pop        (pop),
        .rsp        (rsp)
    );

endmodule

`default_nettype wire

// File: hdl/mccf_checker.sv
// Port-level checks of the motor channel command sequencer, bound to the top level.
`default_nettype none

`include "motor_channel_command_fsm_assert.svh"

module mccf_checker (
    input wire                           clk,
    input wire                           rst_n,
    input wire                           rsp_valid,
    input wire                           rsp_ready,
    input wire [mccf_pkg::STATUS_W-1:0]  status,
    input wire                           calib_done,
    input wire                           initialized,
    input wire                           calib_drive
);
    import mccf_pkg::*;

    // a stalled response stays offered
    `MCCF_ASSERT_NEXT(a_rsp_hold, rsp_valid && !rsp_ready, rsp_valid)

    // drive only while calibrating and not yet done
    `MCCF_ASSERT_NOW(a_drive_in_calib, rsp_valid && calib_drive, status == MODE_CALIB && !calib_done)

    // enable is only reachable with calibration done
    `MCCF_ASSERT_NOW(a_enable_calibrated, rsp_valid && status == MODE_ENABLE, calib_done)

    // a channel that finished set-up has left init for good
    `MCCF_ASSERT_NOW(a_ready_not_init, rsp_valid && initialized, status != MODE_INIT)

endmodule

bind motor_channel_command_fsm mccf_checker u_mccf_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .rsp_valid   (rsp.valid),
    .rsp_ready   (rsp.ready),
    .status      (rsp.status),
    .calib_done  (rsp.calib_done),
    .initialized (rsp.initialized),
    .calib_drive (rsp.calib_drive)
);

`default_nettype wire

// File: test/motor_channel_command_fsm_checker.sv
// Checker for the motor channel command sequencer: predicts each response beat and compares.
module motor_channel_command_fsm_checker #(
    parameter int CHANNELS = mccf_pkg::CHANNELS_DEF
) (
    input  logic clk,
    input  logic rst_n,
    mccf_cmd_if  cmd,
    mccf_rsp_if  rsp,
    output int   failures,
    output int   pending
);
    import mccf_pkg::*;

    typedef struct packed {
        logic                accepted;
        logic                channel_out;
        logic [STATUS_W-1:0] status;
        logic                calib_done;
        logic                initialized;
        logic                calib_drive;
        logic [REJ_W-1:0]    reject_count;
    } outcome_t;

    // mirrored channel state; only the steering setting bits are kept
    mode_t            ch_mode       [CHANNELS];
    bit               calibrated    [CHANNELS];
    bit               setup_started [CHANNELS];
    bit               setup_done    [CHANNELS];
    bit               ch_ready      [CHANNELS];
    bit               cal_en        [CHANNELS];
    bit               tmo_en        [CHANNELS];
    logic [REJ_W-1:0] rejects       [CHANNELS];
    bit               init_seen;

    outcome_t outcome_q[$];
    outcome_t want;
    outcome_t got;

    function automatic bit try_mode_change(int ch, mode_t next);
        bit ok;
        mode_t cur;
        cur = ch_mode[ch];
        ok  = 1'b0;
        case (next)
            MODE_ENABLE:  ok = (cur == MODE_CALIB || cur == MODE_DISABLE) && calibrated[ch];
            MODE_DISABLE: ok = (cur == MODE_ENABLE);
            MODE_CALIB:   ok = (cur == MODE_DISABLE || cur == MODE_CHANGE) && setup_done[ch];
            MODE_CHANGE:  ok = (cur == MODE_INIT || cur == MODE_CHANGE || cur == MODE_DISABLE);
            default:      ok = 1'b0;
        endcase
        if (ok) begin
            if (next == MODE_CALIB || next == MODE_CHANGE)
                calibrated[ch] = 1'b0;
            ch_mode[ch] = next;
        end else if (rejects[ch] != '1) begin
            rejects[ch] = rejects[ch] + 1'b1;
        end
        return ok;
    endfunction

    function automatic outcome_t sequencer_outcome(logic [KIND_W-1:0] kind, logic chan,
                                                   logic [WORD_W-1:0] lo, logic sw);
        outcome_t r;
        bit acc;
        bit chan_ok;
        int ch;
        acc     = 1'b0;
        ch      = int'(chan);
        chan_ok = ch < CHANNELS;
        if (kind == KIND_TIMEOUT) begin
            for (int c = 0; c < CHANNELS; c++) begin
                if (ch_mode[c] == MODE_ENABLE && tmo_en[c]) begin
                    ch_mode[c] = MODE_DISABLE;
                    acc = 1'b1;
                end
            end
        end else if (chan_ok) begin
            case (kind)
                KIND_INIT1, KIND_INIT2, KIND_INIT3:
                    if (!ch_ready[ch]) begin
                        if (kind == KIND_INIT1)
                            cal_en[ch] = lo[CAL_EN_LSB +: 8] != 8'd0;
                        if (kind == KIND_INIT3)
                            init_seen = 1'b1;
                        acc = 1'b1;
                    end
                KIND_CTRL1:
                    if (init_seen && try_mode_change(ch, MODE_CHANGE)) begin
                        setup_started[ch] = 1'b1;
                        setup_done[ch]    = 1'b0;
                        acc = 1'b1;
                    end
                KIND_CTRL2, KIND_CTRL3, KIND_CTRL4:
                    if (init_seen && setup_started[ch]) begin
                        if (kind == KIND_CTRL4) begin
                            tmo_en[ch]        = lo[TMO_EN_LSB +: 8] == TMO_EN_CODE;
                            setup_started[ch] = 1'b0;
                            setup_done[ch]    = 1'b1;
                            ch_ready[ch]      = 1'b1;
                        end
                        acc = 1'b1;
                    end
                KIND_CALIB:   acc = try_mode_change(ch, MODE_CALIB);
                KIND_ENABLE:  acc = try_mode_change(ch, MODE_ENABLE);
                KIND_DISABLE: acc = try_mode_change(ch, MODE_DISABLE);
                KIND_TARGET:  acc = 1'b1;
                KIND_TICK:
                    if (ch_mode[ch] == MODE_CALIB) begin
                        if (sw || !cal_en[ch])
                            calibrated[ch] = 1'b1;
                        acc = 1'b1;
                    end
                default: acc = 1'b0;
            endcase
        end
        r = '0;
        r.accepted    = acc;
        r.channel_out = chan;
        if (chan_ok) begin
            r.status       = ch_mode[ch];
            r.calib_done   = calibrated[ch];
            r.initialized  = ch_ready[ch];
            r.calib_drive  = ch_mode[ch] == MODE_CALIB && cal_en[ch] && !calibrated[ch];
            r.reject_count = rejects[ch];
        end
        return r;
    endfunction

    task automatic check_field(string name, int exp_val, int act_val);
        if (exp_val != act_val) begin
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, exp_val, act_val);
            failures = failures + 1;
        end
    endtask

    // response side first: a beat can never answer a command taken at the same edge
    always @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            for (int c = 0; c < CHANNELS; c++) begin
                ch_mode[c]       = MODE_INIT;
                calibrated[c]    = 1'b0;
                setup_started[c] = 1'b0;
                setup_done[c]    = 1'b0;
                ch_ready[c]      = 1'b0;
                cal_en[c]        = 1'b0;
                tmo_en[c]        = 1'b0;
                rejects[c]       = '0;
            end
            init_seen = 1'b0;
            outcome_q.delete();
            failures = 0;
            pending  = 0;
        end else begin
            if (rsp.valid && rsp.ready) begin
                got = '{rsp.accepted, rsp.channel_out, rsp.status, rsp.calib_done,
                        rsp.initialized, rsp.calib_drive, rsp.reject_count};
                if (outcome_q.size() == 0) begin
                    $display("%0t: response beat with none expected, actual %h", $time, got);
                    failures = failures + 1;
                end else begin
                    want = outcome_q.pop_front();
                    check_field("accepted", want.accepted, got.accepted);
                    check_field("channel_out", want.channel_out, got.channel_out);
                    check_field("status", want.status, got.status);
                    check_field("calib_done", want.calib_done, got.calib_done);
                    check_field("initialized", want.initialized, got.initialized);
                    check_field("calib_drive", want.calib_drive, got.calib_drive);
                    check_field("reject_count", want.reject_count, got.reject_count);
                end
            end
            if (cmd.valid && cmd.ready)
                outcome_q.push_back(sequencer_outcome(cmd.kind, cmd.channel, cmd.word_low,
                                                      cmd.limit_switch));
            pending = outcome_q.size();
        end
    end

endmodule

// File: test/motor_channel_command_fsm_tb.sv
// Testbench top for the motor channel command sequencer: stimulus, back-pressure and verdict.
module motor_channel_command_fsm_tb;
    import mccf_pkg::*;

    localparam int CHANNELS   = CHANNELS_DEF;
    localparam int QUIET_MAX  = 2000;   // cycles with no beat on either side before giving up
    localparam int HOLD_LEN   = 400;    // long response stall, well past queue fill
    localparam int RAND_UNTIL = 550;    // directed part plus random beats, about 550 in all

    logic clk = 1'b0;
    logic rst_n;

    mccf_cmd_if cmd_bus ();
    mccf_rsp_if rsp_bus ();

    int failures;
    int pending;

    // burst and hold_req are shared between sender and receiver processes
    bit burst;      // both sides stop idling while set
    bit hold_req;   // asks the receiver for one long stall
    int sent;
    int quiet;

    motor_channel_command_fsm #(
        .CHANNELS (CHANNELS)
    ) u_dut (
        .clk   (clk),
        .rst_n (rst_n),
        .cmd   (cmd_bus),
        .rsp   (rsp_bus)
    );

    motor_channel_command_fsm_checker #(
        .CHANNELS (CHANNELS)
    ) u_checker (
        .clk      (clk),
        .rst_n    (rst_n),
        .cmd      (cmd_bus),
        .rsp      (rsp_bus),
        .failures (failures),
        .pending  (pending)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Offer one command beat and block until it is taken. valid is left high on
    // return so back-to-back beats never drop it; a gap lowers it in the same
    // step that the previous beat was accepted, which is the only assignment then.
    task automatic issue(input logic [KIND_W-1:0] kind, input logic ch,
                         input logic [WORD_W-1:0] lo, input logic [WORD_W-1:0] hi,
                         input logic sw);
        int gap;
        gap = burst ? 0 : $urandom_range(0, 16);
        if (gap != 0)
        begin
            cmd_bus.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        cmd_bus.valid        <= 1'b1;
        cmd_bus.kind         <= kind;
        cmd_bus.channel      <= ch;
        cmd_bus.word_low     <= lo;
        cmd_bus.word_high    <= hi;
        cmd_bus.limit_switch <= sw;
        @(posedge clk);
        while (!cmd_bus.ready) @(posedge clk);
        sent++;
    endtask

    // init1 low word: byte 2 nonzero turns calibration on
    function automatic logic [WORD_W-1:0] init1_word(bit cal);
        logic [WORD_W-1:0] w;
        w = $urandom();
        w[CAL_EN_LSB +: 8] = cal ? (w[CAL_EN_LSB +: 8] | 8'h01) : 8'h00;
        return w;
    endfunction

    // ctrl4 low word: byte 3 equal to the enable code arms the timeout monitor
    function automatic logic [WORD_W-1:0] ctrl4_word(bit tmo);
        logic [WORD_W-1:0] w;
        w = $urandom();
        if (tmo)
            w[TMO_EN_LSB +: 8] = TMO_EN_CODE;
        return w;
    endfunction

    // full well-formed set-up: optional init words, then the four control parts
    task automatic setup_channel(input logic ch, input bit with_init, input bit cal,
                                 input bit tmo);
        if (with_init)
        begin
            issue(KIND_INIT1, ch, init1_word(cal), $urandom(), $urandom_range(0, 1));
            issue(KIND_INIT2, ch, $urandom(), $urandom(), $urandom_range(0, 1));
            issue(KIND_INIT3, ch, $urandom(), $urandom(), $urandom_range(0, 1));
        end
        issue(KIND_CTRL1, ch, $urandom(), $urandom(), $urandom_range(0, 1));
        issue(KIND_CTRL2, ch, $urandom(), $urandom(), $urandom_range(0, 1));
        issue(KIND_CTRL3, ch, $urandom(), $urandom(), $urandom_range(0, 1));
        issue(KIND_CTRL4, ch, ctrl4_word(tmo), $urandom(), $urandom_range(0, 1));
    endtask

    // Response side: a fresh stall per beat, plus one long hold on request.
    initial
    begin
        int stall;
        rsp_bus.ready <= 1'b0;
        @(posedge clk);
        while (!rst_n) @(posedge clk);
        forever
        begin
            if (hold_req)
            begin
                hold_req = 1'b0;
                rsp_bus.ready <= 1'b0;
                repeat (HOLD_LEN) @(posedge clk);
            end
            stall = burst ? 0 : $urandom_range(0, 16);
            if (stall != 0)
            begin
                rsp_bus.ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            rsp_bus.ready <= 1'b1;
            @(posedge clk);
            while (!rsp_bus.valid) @(posedge clk);
        end
    end

    // Watchdog: any beat on either side restarts the count.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            quiet <= 0;
        else if ((cmd_bus.valid && cmd_bus.ready) || (rsp_bus.valid && rsp_bus.ready))
            quiet <= 0;
        else
        begin
            quiet <= quiet + 1;
            if (quiet >= QUIET_MAX)
            begin
                $display("Test completed with failures");
                $finish;
            end
        end
    end

    initial
    begin
        logic              ch;
        logic [KIND_W-1:0] k;
        bit                hold_done;
        bit                pause_done;

        hold_done  = 1'b0;
        pause_done = 1'b0;
        burst      = 1'b0;
        hold_req   = 1'b0;
        sent       = 0;

        rst_n                <= 1'b0;
        cmd_bus.valid        <= 1'b0;
        cmd_bus.kind         <= KIND_INIT1;
        cmd_bus.channel      <= 1'b0;
        cmd_bus.word_low     <= '0;
        cmd_bus.word_high    <= '0;
        cmd_bus.limit_switch <= 1'b0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;

        // --- directed ---
        // before init3: ctrl1 is refused without counting, mode changes count
        issue(KIND_CTRL1, 1'b0, '0, '0, 1'b0);
        issue(KIND_CALIB, 1'b0, '1, '1, 1'b1);
        issue(KIND_ENABLE, 1'b0, '0, '1, 1'b0);
        issue(KIND_DISABLE, 1'b0, '1, '0, 1'b1);
        issue(KIND_TICK, 1'b0, '0, '0, 1'b1);       // not calibrating: refused
        issue(KIND_TIMEOUT, 1'b0, '0, '0, 1'b0);    // nothing enabled
        // channel 0: calibration on, timeout monitor on
        issue(KIND_INIT1, 1'b0, '1, '0, 1'b0);
        issue(KIND_INIT2, 1'b0, '0, '1, 1'b1);
        issue(KIND_INIT3, 1'b0, '1, '1, 1'b0);
        issue(KIND_CTRL2, 1'b0, '0, '0, 1'b0);      // set-up not started
        issue(KIND_CTRL1, 1'b0, '1, '1, 1'b1);
        issue(KIND_CTRL2, 1'b0, '1, '0, 1'b0);
        issue(KIND_CTRL3, 1'b0, '0, '1, 1'b1);
        issue(KIND_CTRL4, 1'b0, 32'h0100_0000, '1, 1'b0);
        issue(KIND_INIT1, 1'b0, '0, '0, 1'b0);      // ready channel refuses init
        issue(KIND_ENABLE, 1'b0, '0, '0, 1'b0);     // not calibrated
        issue(KIND_CALIB, 1'b0, '0, '0, 1'b0);
        issue(KIND_TICK, 1'b0, '1, '1, 1'b0);       // switch open, drive stays on
        issue(KIND_TICK, 1'b0, '0, '0, 1'b1);
        issue(KIND_ENABLE, 1'b0, '0, '0, 1'b0);
        issue(KIND_TIMEOUT, 1'b1, '0, '0, 1'b0);    // drops ch0, reports ch1
        issue(KIND_ENABLE, 1'b0, '0, '0, 1'b0);     // from disable, still calibrated
        issue(KIND_CTRL1, 1'b0, '0, '0, 1'b0);      // refused from enable
        issue(KIND_TARGET, 1'b0, '1, '1, 1'b1);
        issue(4'hD, 1'b1, '1, '1, 1'b1);            // unknown kinds are ignored
        issue(4'hF, 1'b0, '0, '0, 1'b0);
        // channel 1: calibration off, so a tick with the switch open still ends it
        setup_channel(1'b1, 1'b1, 1'b0, 1'b0);
        issue(KIND_CALIB, 1'b1, '0, '0, 1'b0);
        issue(KIND_TICK, 1'b1, '0, '0, 1'b0);

        // --- random: mostly well-formed sequences, some broken ones and noise ---
        while (sent < RAND_UNTIL)
        begin
            ch    = $urandom_range(0, 1);
            burst = ($urandom_range(0, 4) == 0);
            if (!hold_done && sent >= 200)
            begin
                hold_done = 1'b1;
                hold_req  = 1'b1;
            end
            if (!pause_done && sent >= 400)
            begin
                // sender pause: drain everything before going on
                pause_done = 1'b1;
                cmd_bus.valid <= 1'b0;
                @(posedge clk);
                while (pending != 0) @(posedge clk);
            end
            case ($urandom_range(0, 9))
                0:
                    setup_channel(ch, $urandom_range(0, 1), $urandom_range(0, 1),
                                  $urandom_range(0, 1));
                1, 2, 3:
                begin
                    issue(KIND_CALIB, ch, $urandom(), $urandom(), $urandom_range(0, 1));
                    repeat ($urandom_range(0, 3))
                        issue(KIND_TICK, ch, $urandom(), $urandom(), $urandom_range(0, 1));
                    issue(KIND_ENABLE, ch, $urandom(), $urandom(), $urandom_range(0, 1));
                    if ($urandom_range(0, 1))
                        issue(KIND_TIMEOUT, $urandom_range(0, 1), $urandom(), $urandom(),
                              $urandom_range(0, 1));
                    if ($urandom_range(0, 1))
                        issue(KIND_DISABLE, ch, $urandom(), $urandom(), $urandom_range(0, 1));
                end
                4, 5:
                begin
                    k = $urandom_range(KIND_CALIB, KIND_TIMEOUT);
                    issue(k, ch, $urandom(), $urandom(), $urandom_range(0, 1));
                end
                6:
                begin
                    // broken set-up: ctrl1 then stray control parts
                    issue(KIND_CTRL1, ch, $urandom(), $urandom(), $urandom_range(0, 1));
                    repeat ($urandom_range(1, 3))
                    begin
                        k = $urandom_range(KIND_CTRL2, KIND_CTRL4);
                        issue(k, ch, $urandom(), $urandom(), $urandom_range(0, 1));
                    end
                end
                7:
                begin
                    k = $urandom_range(0, 15);
                    issue(k, ch, $urandom(), $urandom(), $urandom_range(0, 1));
                end
                8:
                begin
                    k = $urandom_range(KIND_INIT1, KIND_INIT3);
                    issue(k, ch, init1_word($urandom_range(0, 1)), $urandom(),
                          $urandom_range(0, 1));
                end
                default:
                    issue(KIND_TARGET, ch, $urandom(), $urandom(), $urandom_range(0, 1));
            endcase
        end
        burst = 1'b0;

        // drain, then let the pipeline run dry before the verdict
        cmd_bus.valid <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
        repeat (10) @(posedge clk);
        if (failures == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule
